// ===== rtl/bpc_pkg.sv =====
// Shared types and widths for the barometric pressure and temperature compensation block.
package bpc_pkg;

  localparam int RAW_W       = 24;
  localparam int SCALED_W    = 32;
  localparam int TQ_W        = 16;
  localparam int PQ_W        = 22;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Coefficient register indexes, taken from byte address bits 4:2.
  typedef enum logic [2:0] {
    REG_TEMP_PAIR, REG_P_OFFSET, REG_P_LIN, REG_T_CROSS,
    REG_X_LIN, REG_P_QUAD, REG_X_QUAD, REG_P_CUBIC
  } coeff_reg_t;

  // Compensation coefficients, already sign extended from their register fields.
  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coeff_t;

  // One scaled sample pair with its finished temperature, as held in the queue.
  typedef struct packed {
    logic signed [SCALED_W-1:0] x;
    logic signed [SCALED_W-1:0] t;
    logic signed [TQ_W-1:0]     tq8;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/bpc_ifs.sv =====
// Stream interfaces for the raw sample input and the compensated result output.
interface bpc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpc_pkg::RAW_W-1:0]   raw_pressure;
  logic signed [bpc_pkg::RAW_W-1:0]   raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpc_pkg::TQ_W-1:0]    temperature_q8;
  logic signed [bpc_pkg::PQ_W-1:0]    pressure_hpa_q10;

  modport source (output valid, output temperature_q8, output pressure_hpa_q10, input ready);
  modport sink   (input valid, input temperature_q8, input pressure_hpa_q10, output ready);
endinterface

// ===== rtl/bpc_front.sv =====
// Front end: accepts raw samples, scales them to Q1.30 and finishes the temperature.
module bpc_front (
  input  logic                clk,
  input  logic                rst_n,
  bpc_in_if.sink              in_chan,
  input  bpc_pkg::coeff_t     coeff,
  input  bpc_pkg::q_status_t  q_status,
  output logic                push,
  output bpc_pkg::item_t      push_data
);
  import bpc_pkg::*;

  localparam int STAGES = 5;
  // ceil(2^32 / 15): exact reciprocal for dividends below 2^28
  localparam logic [28:0]        RECIP15      = 29'd286331154;
  // 15 * 2^23 keeps the biased dividend positive without disturbing the floor
  localparam logic signed [28:0] SCALE_OFFSET = 29'sd125829120;
  localparam logic signed [31:0] SCALE_BIAS   = 32'sd8388608;
  localparam logic signed [22:0] TQ_MAX       = 23'sd32767;
  localparam logic signed [22:0] TQ_MIN       = -23'sd32768;

  logic                         en;
  logic [STAGES-1:0]            fv_r;
  logic signed [RAW_W-1:0]      rp_r, rt_r;
  logic [56:0]                  xprod_r, tprod_r, xprod_nxt, tprod_nxt;
  logic signed [SCALED_W-1:0]   xbase_r, tbase_r;
  logic signed [SCALED_W-1:0]   x_r, t_r, x_nxt, t_nxt;
  logic signed [SCALED_W-1:0]   x_d_r, t_d_r, x_e_r, t_e_r;
  logic signed [43:0]           c1t_r, c1t_nxt;
  logic signed [44:0]           tq30;
  logic signed [22:0]           ts;
  logic signed [TQ_W-1:0]       tq_r, tq_nxt;

  // raw * 2^11 / 15 is raw * 136 plus floor(raw * 8 / 15); this gives the biased raw * 8.
  function automatic logic [27:0] biased8(input logic signed [RAW_W-1:0] raw);
    logic signed [28:0] w;
    w = (29'(raw) <<< 3) + SCALE_OFFSET;
    return w[27:0];
  endfunction

  function automatic logic signed [SCALED_W-1:0] times136(input logic signed [RAW_W-1:0] raw);
    return (32'(raw) <<< 7) + (32'(raw) <<< 3);
  endfunction

  assign en            = !q_status.full;
  assign in_chan.ready = en;

  assign xprod_nxt = 57'(biased8(rp_r)) * 57'(RECIP15);
  assign tprod_nxt = 57'(biased8(rt_r)) * 57'(RECIP15);
  assign x_nxt     = xbase_r + $signed(32'(xprod_r[56:32])) - SCALE_BIAS;
  assign t_nxt     = tbase_r + $signed(32'(tprod_r[56:32])) - SCALE_BIAS;
  assign c1t_nxt   = 44'(t_r) * 44'(coeff.c1);

  always_comb begin
    tq30 = (45'(coeff.c0) <<< 29) + 45'(c1t_r);
    ts   = $signed(tq30[44:22]);
    if (ts > TQ_MAX) begin
      tq_nxt = TQ_MAX[15:0];
    end else if (ts < TQ_MIN) begin
      tq_nxt = TQ_MIN[15:0];
    end else begin
      tq_nxt = ts[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[STAGES-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r    <= in_chan.raw_pressure;
      rt_r    <= in_chan.raw_temperature;
      xprod_r <= xprod_nxt;
      tprod_r <= tprod_nxt;
      xbase_r <= times136(rp_r);
      tbase_r <= times136(rt_r);
      x_r     <= x_nxt;
      t_r     <= t_nxt;
      x_d_r   <= x_r;
      t_d_r   <= t_r;
      c1t_r   <= c1t_nxt;
      x_e_r   <= x_d_r;
      t_e_r   <= t_d_r;
      tq_r    <= tq_nxt;
    end
  end

  assign push         = fv_r[STAGES-1] && en;
  assign push_data.x  = x_e_r;
  assign push_data.t  = t_e_r;
  assign push_data.tq8 = tq_r;

endmodule

// ===== rtl/bpc_queue.sv =====
// Short queue that decouples the front end from the polynomial back end.
module bpc_queue #(
  parameter int DEPTH = bpc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bpc_pkg::item_t      push_data,
  input  logic                pop,
  output bpc_pkg::item_t      pop_data,
  output bpc_pkg::q_status_t  q_status
);
  import bpc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  item_t             rd_data_r;
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // The read register doubles as the first stage of the back end.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign pop_data       = rd_data_r;
  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.empty = (count_r == '0);

`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow a lone push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("queue empty but pointers differ");
`endif

endmodule

// ===== rtl/bpc_back.sv =====
// Back end: evaluates the pressure polynomial, divides by 100 and drives the result channel.
module bpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bpc_pkg::coeff_t     coeff,
  input  bpc_pkg::q_status_t  q_status,
  output logic                pop,
  input  bpc_pkg::item_t      pop_data,
  bpc_out_if.source           out_chan
);
  import bpc_pkg::*;

  localparam int STAGES = 12;
  localparam logic signed [34:0] PS_MIN  = -35'sd209715200;
  localparam logic signed [34:0] PS_MAX  = 35'sd209715199;
  // ceil(2^32 / 25): exact reciprocal for dividends below 2^27
  localparam logic [27:0]        RECIP25 = 28'd171798692;
  localparam logic [22:0]        PQ_BIAS = 23'd2097152;

  logic               ben;
  logic [STAGES-1:0]  bv_r;

  logic signed [TQ_W-1:0] tq_b1_r, tq_b2_r, tq_b3_r, tq_b4_r, tq_b5_r;
  logic signed [TQ_W-1:0] tq_b6_r, tq_b7_r, tq_b8_r, tq_b9_r, tq_b10_r;
  logic signed [SCALED_W-1:0] x_b1_r, x_b2_r, x_b3_r, x_b4_r, x_b5_r;

  logic signed [47:0] xc30_b1_r, xc21_b1_r, tc01_b1_r;
  logic signed [63:0] txf_b1_r;
  logic signed [47:0] inner_b2_r, cross_b2_r, tc01_b2_r;
  logic signed [31:0] tx_b2_r;
  logic signed [56:0] pa_lo_b3_r, pc_lo_b3_r;
  logic signed [55:0] pa_hi_b3_r, pc_hi_b3_r;
  logic signed [47:0] tc01_b3_r, tc01_b4_r;
  logic signed [79:0] xi_full, xc_full;
  logic signed [49:0] xi_b4_r, xc_b4_r;
  logic signed [50:0] lin_b5_r;
  logic signed [51:0] part_b5_r, part_b6_r, part_b7_r;
  logic signed [58:0] pb_lo_b6_r;
  logic signed [56:0] pb_hi_b6_r;
  logic signed [82:0] poly_full;
  logic signed [52:0] poly_b7_r;
  logic signed [54:0] sum_b8_r;
  logic signed [34:0] ps, ps_clamped, ps_biased;
  logic [26:0]        v_b9_r, v_nxt;
  logic [54:0]        qprod_b10_r;
  logic [22:0]        q_b10;

  logic signed [TQ_W-1:0] temperature_q8_r;
  logic signed [PQ_W-1:0] pressure_hpa_q10_r;

  // The whole back end advances together; the last stage is the output register.
  assign ben = !bv_r[STAGES-1] || out_chan.ready;
  assign pop = ben && !q_status.empty;

  assign xi_full   = (80'(pa_hi_b3_r) <<< 24) + 80'(pa_lo_b3_r);
  assign xc_full   = (80'(pc_hi_b3_r) <<< 24) + 80'(pc_lo_b3_r);
  assign poly_full = (83'(pb_hi_b6_r) <<< 26) + 83'(pb_lo_b6_r);

  // Clamping before the divide keeps the quotient inside the output range.
  always_comb begin
    ps = $signed(sum_b8_r[54:20]);
    if (ps < PS_MIN) begin
      ps_clamped = PS_MIN;
    end else if (ps > PS_MAX) begin
      ps_clamped = PS_MAX;
    end else begin
      ps_clamped = ps;
    end
    ps_biased = ps_clamped - PS_MIN;
    v_nxt     = ps_biased[28:2];
  end

  assign q_b10 = qprod_b10_r[54:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (ben) begin
      bv_r <= {bv_r[STAGES-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      // products on the scaled inputs
      x_b1_r    <= pop_data.x;
      tq_b1_r   <= pop_data.tq8;
      xc30_b1_r <= 48'(pop_data.x) * 48'(coeff.c30);
      xc21_b1_r <= 48'(pop_data.x) * 48'(coeff.c21);
      txf_b1_r  <= 64'(pop_data.x) * 64'(pop_data.t);
      tc01_b1_r <= 48'(pop_data.t) * 48'(coeff.c01);
      // inner brackets
      x_b2_r     <= x_b1_r;
      tq_b2_r    <= tq_b1_r;
      inner_b2_r <= (48'(coeff.c20) <<< 30) + xc30_b1_r;
      cross_b2_r <= (48'(coeff.c11) <<< 30) + xc21_b1_r;
      tx_b2_r    <= $signed(txf_b1_r[61:30]);
      tc01_b2_r  <= tc01_b1_r;
      // wide products split into two partial products each
      x_b3_r     <= x_b2_r;
      tq_b3_r    <= tq_b2_r;
      pa_lo_b3_r <= 57'(x_b2_r) * 57'($signed({1'b0, inner_b2_r[23:0]}));
      pa_hi_b3_r <= 56'(x_b2_r) * 56'($signed(inner_b2_r[47:24]));
      pc_lo_b3_r <= 57'(tx_b2_r) * 57'($signed({1'b0, cross_b2_r[23:0]}));
      pc_hi_b3_r <= 56'(tx_b2_r) * 56'($signed(cross_b2_r[47:24]));
      tc01_b3_r  <= tc01_b2_r;
      x_b4_r     <= x_b3_r;
      tq_b4_r    <= tq_b3_r;
      xi_b4_r    <= xi_full[79:30];
      xc_b4_r    <= xc_full[79:30];
      tc01_b4_r  <= tc01_b3_r;
      x_b5_r     <= x_b4_r;
      tq_b5_r    <= tq_b4_r;
      lin_b5_r   <= (51'(coeff.c10) <<< 30) + 51'(xi_b4_r);
      part_b5_r  <= (52'(coeff.c00) <<< 30) + 52'(tc01_b4_r) + 52'(xc_b4_r);
      tq_b6_r    <= tq_b5_r;
      pb_lo_b6_r <= 59'(x_b5_r) * 59'($signed({1'b0, lin_b5_r[25:0]}));
      pb_hi_b6_r <= 57'(x_b5_r) * 57'($signed(lin_b5_r[50:26]));
      part_b6_r  <= part_b5_r;
      tq_b7_r    <= tq_b6_r;
      poly_b7_r  <= poly_full[82:30];
      part_b7_r  <= part_b6_r;
      // final sum, then divide by 100 * 2^20
      tq_b8_r    <= tq_b7_r;
      sum_b8_r   <= 55'(part_b7_r) + 55'(poly_b7_r);
      tq_b9_r    <= tq_b8_r;
      v_b9_r     <= v_nxt;
      tq_b10_r   <= tq_b9_r;
      qprod_b10_r <= 55'(v_b9_r) * 55'(RECIP25);
      temperature_q8_r   <= tq_b10_r;
      pressure_hpa_q10_r <= $signed(22'(q_b10 - PQ_BIAS));
    end
  end

  assign out_chan.valid            = bv_r[STAGES-1];
  assign out_chan.temperature_q8   = temperature_q8_r;
  assign out_chan.pressure_hpa_q10 = pressure_hpa_q10_r;

`ifndef SYNTH
  a_no_pop_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (bv_r[STAGES-1] && !out_chan.ready) |-> !pop)
    else $error("queue popped while the result stage was stalled");
`endif

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Top level of the barometric pressure and temperature compensation block.
//
// Usage: raw 24-bit pressure and temperature samples arrive as transactions on in_chan;
// each produces exactly one transaction on out_chan carrying the compensated temperature
// (1/256 degree C) and pressure (1/1024 hPa), both saturated. Results leave in input order.
// The eight coefficient registers sit on the cfg_ APB port at byte address 4*index and
// should only be written while no sample is in flight.
//
// Throughput is one transaction per cycle while the receiver is ready: the front end
// (scaling and temperature, 5 stages) and the back end (pressure polynomial, 12 stages
// including the output register) are both fully pipelined, with each wide product split
// over two multipliers that share a stage.
//
// When the receiver stalls, the back end freezes in place and stops popping the queue; the
// front end keeps accepting until the QUEUE_DEPTH-entry queue fills, after which in_chan
// ready drops. Reset is synchronous and active low: it empties the pipelines and the queue
// and clears all coefficients to zero. There is no clearing pass.
module baro_pressure_temp_compensation #(
  parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bpc_in_if.sink                            in_chan,
  bpc_out_if.source                         out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bpc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import bpc_pkg::*;

  logic [23:0] temp_pair_r;
  logic [19:0] p_offset_r, p_lin_r;
  logic [15:0] t_cross_r, x_lin_r, p_quad_r, x_quad_r, p_cubic_r;
  logic [2:0]  reg_idx;
  logic        cfg_write;

  coeff_t      coeff;
  q_status_t   q_status;
  logic        push, pop;
  item_t       push_data, pop_data;

  // Register indexes are taken from byte address bits 4:2.
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // Bits above each register's width are dropped on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_pair_r <= '0;
      p_offset_r  <= '0;
      p_lin_r     <= '0;
      t_cross_r   <= '0;
      x_lin_r     <= '0;
      p_quad_r    <= '0;
      x_quad_r    <= '0;
      p_cubic_r   <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_TEMP_PAIR: temp_pair_r <= cfg_pwdata[23:0];
        REG_P_OFFSET:  p_offset_r  <= cfg_pwdata[19:0];
        REG_P_LIN:     p_lin_r     <= cfg_pwdata[19:0];
        REG_T_CROSS:   t_cross_r   <= cfg_pwdata[15:0];
        REG_X_LIN:     x_lin_r     <= cfg_pwdata[15:0];
        REG_P_QUAD:    p_quad_r    <= cfg_pwdata[15:0];
        REG_X_QUAD:    x_quad_r    <= cfg_pwdata[15:0];
        REG_P_CUBIC:   p_cubic_r   <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_PAIR: cfg_prdata = 32'(temp_pair_r);
      REG_P_OFFSET:  cfg_prdata = 32'(p_offset_r);
      REG_P_LIN:     cfg_prdata = 32'(p_lin_r);
      REG_T_CROSS:   cfg_prdata = 32'(t_cross_r);
      REG_X_LIN:     cfg_prdata = 32'(x_lin_r);
      REG_P_QUAD:    cfg_prdata = 32'(p_quad_r);
      REG_X_QUAD:    cfg_prdata = 32'(x_quad_r);
      REG_P_CUBIC:   cfg_prdata = 32'(p_cubic_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // The temperature pair packs two 12-bit signed fields; the others are signed as a whole.
  assign coeff.c0  = $signed(temp_pair_r[23:12]);
  assign coeff.c1  = $signed(temp_pair_r[11:0]);
  assign coeff.c00 = $signed(p_offset_r);
  assign coeff.c10 = $signed(p_lin_r);
  assign coeff.c01 = $signed(t_cross_r);
  assign coeff.c11 = $signed(x_lin_r);
  assign coeff.c20 = $signed(p_quad_r);
  assign coeff.c21 = $signed(x_quad_r);
  assign coeff.c30 = $signed(p_cubic_r);

  bpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .coeff     (coeff),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  bpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  bpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .coeff    (coeff),
    .q_status (q_status),
    .pop      (pop),
    .pop_data (pop_data),
    .out_chan (out_chan)
  );

endmodule
